FILE: rtl/core/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg: shared types and constants for the IR remote pulse decoder
// Frame length, register map, command codes and the command-to-action map.
// ----------------------------------------------------------------------------
package irpd_pkg;

	localparam int FRAME_BITS = 32;
	localparam int CNT_W      = $clog2(FRAME_BITS);
	localparam int CODE_W     = 32;
	localparam int TICK_W     = 8;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	typedef enum logic [2:0] {
		REG_START_MIN   = 3'd0,
		REG_TIMEOUT_LEN = 3'd1,
		REG_ONE_MIN     = 3'd2,
		REG_ONE_MAX     = 3'd3,
		REG_ZERO_MIN    = 3'd4,
		REG_ZERO_MAX    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ACT_FORWARD    = 3'd0,
		ACT_BACK       = 3'd1,
		ACT_SPIN_LEFT  = 3'd2,
		ACT_SPIN_RIGHT = 3'd3,
		ACT_STOP       = 3'd4
	} action_t;

	localparam logic [7:0] CMD_FORWARD    = 8'hB1;
	localparam logic [7:0] CMD_BACK       = 8'hD4;
	localparam logic [7:0] CMD_SPIN_LEFT  = 8'h91;
	localparam logic [7:0] CMD_SPIN_RIGHT = 8'hE1;

	localparam logic [TICK_W-1:0] RST_START_MIN   = 8'd200;
	localparam logic [TICK_W-1:0] RST_TIMEOUT_LEN = 8'd250;
	localparam logic [TICK_W-1:0] RST_ONE_MIN     = 8'd60;
	localparam logic [TICK_W-1:0] RST_ONE_MAX     = 8'd90;
	localparam logic [TICK_W-1:0] RST_ZERO_MIN    = 8'd10;
	localparam logic [TICK_W-1:0] RST_ZERO_MAX    = 8'd50;

	function automatic action_t map_action(input logic [7:0] cmd);
		action_t act;
		unique case (cmd)
			CMD_FORWARD:    act = ACT_FORWARD;
			CMD_BACK:       act = ACT_BACK;
			CMD_SPIN_LEFT:  act = ACT_SPIN_LEFT;
			CMD_SPIN_RIGHT: act = ACT_SPIN_RIGHT;
			default:        act = ACT_STOP;
		endcase
		return act;
	endfunction

endpackage

FILE: rtl/core/ir_remote_pulse_decoder.sv
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder: NEC-style IR frame decoder
// Pulse items are registered in s1 and classified there; a completed frame's result is registered in s2.
// Throughput: one pulse item per cycle while in_stall is low; one compare-and-shift step per item.
// Reset: frame state cleared, window registers at their defaults.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder
	import irpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [TICK_W-1:0]   high_time,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CODE_W-1:0]   code,
	output logic [7:0]          command,
	output logic [2:0]          action,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	logic [TICK_W-1:0] start_min_q, timeout_len_q, one_min_q, one_max_q;
	logic [TICK_W-1:0] zero_min_q, zero_max_q;

	logic              valid_s1;
	logic [TICK_W-1:0] high_time_s1;

	logic              armed_q;
	logic [CNT_W-1:0]  bit_count_q;
	logic [CODE_W-1:0] shift_code_q;

	logic              out_valid_s2;
	logic [CODE_W-1:0] code_s2;
	logic [7:0]        command_s2;
	action_t           action_s2;

	logic              adv, fire, emit;
	logic              is_to, is_start, is_one, is_zero, is_data;
	logic [CNT_W:0]    cnt_next;
	logic [CODE_W-1:0] shifted;
	reg_idx_t          widx;

	// register port
	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_comb begin
		prdata = '0;
		unique case (widx)
			REG_START_MIN:   prdata[TICK_W-1:0] = start_min_q;
			REG_TIMEOUT_LEN: prdata[TICK_W-1:0] = timeout_len_q;
			REG_ONE_MIN:     prdata[TICK_W-1:0] = one_min_q;
			REG_ONE_MAX:     prdata[TICK_W-1:0] = one_max_q;
			REG_ZERO_MIN:    prdata[TICK_W-1:0] = zero_min_q;
			REG_ZERO_MAX:    prdata[TICK_W-1:0] = zero_max_q;
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_min_q   <= RST_START_MIN;
			timeout_len_q <= RST_TIMEOUT_LEN;
			one_min_q     <= RST_ONE_MIN;
			one_max_q     <= RST_ONE_MAX;
			zero_min_q    <= RST_ZERO_MIN;
			zero_max_q    <= RST_ZERO_MAX;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_START_MIN:   start_min_q   <= pwdata[TICK_W-1:0];
				REG_TIMEOUT_LEN: timeout_len_q <= pwdata[TICK_W-1:0];
				REG_ONE_MIN:     one_min_q     <= pwdata[TICK_W-1:0];
				REG_ONE_MAX:     one_max_q     <= pwdata[TICK_W-1:0];
				REG_ZERO_MIN:    zero_min_q    <= pwdata[TICK_W-1:0];
				REG_ZERO_MAX:    zero_max_q    <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv      = !out_valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			high_time_s1 <= high_time;
		end
	end

	// pulse classification, timeout > start > one > zero
	assign is_to    = high_time_s1 >= timeout_len_q;
	assign is_start = high_time_s1 >= start_min_q;
	assign is_one   = (high_time_s1 >= one_min_q) && (high_time_s1 < one_max_q);
	assign is_zero  = (high_time_s1 >= zero_min_q) && (high_time_s1 < zero_max_q);
	assign is_data  = !is_to && !is_start && (is_one || is_zero) && armed_q;
	assign shifted  = {shift_code_q[CODE_W-2:0], is_one};
	assign cnt_next = {1'b0, bit_count_q} + {{CNT_W{1'b0}}, 1'b1};
	assign emit     = fire && is_data && (cnt_next == (CNT_W+1)'(FRAME_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			bit_count_q  <= '0;
			shift_code_q <= '0;
		end else if (fire) begin
			priority if (is_to || emit) begin
				armed_q      <= 1'b0;
				bit_count_q  <= '0;
				shift_code_q <= '0;
			end else if (is_start) begin
				armed_q      <= 1'b1;
				bit_count_q  <= '0;
				shift_code_q <= '0;
			end else if (is_data) begin
				bit_count_q  <= cnt_next[CNT_W-1:0];
				shift_code_q <= shifted;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_s2    <= shifted;
			command_s2 <= shifted[15:8];
			action_s2  <= map_action(shifted[15:8]);
		end
	end

	assign out_valid = out_valid_s2;
	assign code      = code_s2;
	assign command   = command_s2;
	assign action    = action_s2;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, bit_count_q} < (CNT_W+1)'(FRAME_BITS))
		else $error("bit count past frame length");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (bit_count_q == '0) && (shift_code_q == '0))
		else $error("frame state set while not armed");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_s2 && (command_s2 == code_s2[15:8]))
		else $error("emitted item not presented");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_s2 && out_stall)
		else $error("input stalled without cause");

endmodule
